/* rtl/core/cp0ee_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp0ee_pkg
// Command codes, vectors, cause codes and bit positions for the CP0
// exception entry unit.
// ----------------------------------------------------------------------------
package cp0ee_pkg;

	typedef enum logic [3:0] {
		CMD_CHECK_INTR   = 4'd0,
		CMD_ADDR_ERR     = 4'd1,
		CMD_BREAK        = 4'd2,
		CMD_COP_UNUSABLE = 4'd3,
		CMD_INTERRUPT    = 4'd4,
		CMD_TLB_MISS     = 4'd5,
		CMD_SYSCALL      = 4'd6,
		CMD_WR_STATUS    = 4'd7,
		CMD_WR_INTR      = 4'd8,
		CMD_WR_MASK      = 4'd9
	} cmd_t;

	localparam logic [31:0] VEC_GENERAL = 32'h8000_0180;
	localparam logic [31:0] VEC_REFILL  = 32'h8000_0000;

	localparam int ST_IE  = 0;
	localparam int ST_EXL = 1;
	localparam int ST_ERL = 2;

	localparam logic [31:0] CA_BD = 32'h8000_0000;

	localparam logic [31:0] CODE_INT   = 32'h0000_0000;
	localparam logic [31:0] CODE_RMISS = 32'h0000_0008;
	localparam logic [31:0] CODE_RADE  = 32'h0000_0010;
	localparam logic [31:0] CODE_WADE  = 32'h0000_0014;
	localparam logic [31:0] CODE_SYS   = 32'h0000_0020;
	localparam logic [31:0] CODE_BRK   = 32'h0000_0024;
	localparam logic [31:0] CODE_CPU   = 32'h0000_002C;

	localparam logic [31:0] CTX_KEEP_MASK  = 32'hFF80_000F;
	localparam logic [31:0] CTX_VPN_MASK   = 32'h007F_FFF0;
	localparam logic [31:0] ENTRYHI_MASK   = 32'hFFFF_E000;

	localparam logic [7:0] IP2_LINE = 8'h04;

	localparam int MI_SP = 0;
	localparam int MI_AI = 2;
	localparam int MI_DP = 5;

	typedef struct packed {
		logic [31:0] next_pc;
		logic [31:0] cause;
		logic [31:0] epc;
		logic [31:0] status;
		logic [31:0] badaddr;
		logic [31:0] ctx;
		logic [31:0] entryhi;
		logic [5:0]  intr_word;
		logic        intr_event;
		logic        taken;
	} res_t;

endpackage

/* rtl/core/cp0_exception_entry_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp0_exception_entry_unit
// CP0 exception entry: interrupt merge and check, exception entry with
// vector, cause, EPC and status update, and status/interrupt/mask writes.
// ----------------------------------------------------------------------------
//  channel  | handshake            | beat
//  ---------+----------------------+--------------------------------------
//  in       | in_valid / in_ready  | cmd, delay_slot, cur_pc, fault_addr, ...
//  out      | out_valid/ out_ready | next_pc, cause_out, ... taken
//  cfg      | cfg_valid/ cfg_ready | cfg_data (audio_from_source)
//
//  One beat in per cycle while the output is not stalled; each beat passes
//  through the input register, then the result register. CP0 state
//  updates as a beat leaves the input register, so the next beat sees it.
//  Reset clears all CP0 state, sets audio_from_source and empties both stages.
//  A stalled output holds the input stage; in_ready then drops.
// ----------------------------------------------------------------------------
module cp0_exception_entry_unit
	import cp0ee_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  cmd,
	input  logic        delay_slot,
	input  logic [31:0] cur_pc,
	input  logic [31:0] fault_addr,
	input  logic        from_read,
	input  logic [1:0]  cop_num,
	input  logic        tlb_defined,
	input  logic [2:0]  intr_sources,
	input  logic [31:0] write_value,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] next_pc,
	output logic [31:0] cause_out,
	output logic [31:0] epc_out,
	output logic [31:0] status_out,
	output logic [31:0] badaddr_out,
	output logic [31:0] context_out,
	output logic [31:0] entryhi_out,
	output logic [5:0]  intr_word_out,
	output logic        intr_event,
	output logic        taken
);

	logic        audio_from_source_q;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic        ds_s1;
	logic [31:0] pc_s1;
	logic [31:0] fa_s1;
	logic        rd_s1;
	logic [1:0]  cop_s1;
	logic        tlbdef_s1;
	logic [2:0]  src_s1;
	logic [31:0] wv_s1;

	logic        valid_s2;
	res_t        res_s2;

	logic [31:0] status_q, cause_q, epc_q, badaddr_q, context_q, entryhi_q;
	logic [7:0]  pending_q;
	logic [5:0]  intr_word_q, intr_mask_q;

	logic [31:0] status_d, cause_d, epc_d, badaddr_d, context_d, entryhi_d;
	logic [7:0]  pending_d;
	logic [5:0]  intr_word_d, intr_mask_d;
	logic [31:0] npc;
	logic        ev, tk;
	logic        irq_ok;
	logic [5:0]  merged;
	logic [31:0] epc_entry;
	logic [31:0] bd_bit;

	logic        advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_from_source_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			audio_from_source_q <= cfg_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1    <= cmd_t'(cmd);
			ds_s1     <= delay_slot;
			pc_s1     <= cur_pc;
			fa_s1     <= fault_addr;
			rd_s1     <= from_read;
			cop_s1    <= cop_num;
			tlbdef_s1 <= tlb_defined;
			src_s1    <= intr_sources;
			wv_s1     <= write_value;
		end
	end

	assign irq_ok    = status_q[ST_IE] && !status_q[ST_EXL] && !status_q[ST_ERL];
	assign epc_entry = ds_s1 ? (pc_s1 - 32'd4) : pc_s1;
	assign bd_bit    = ds_s1 ? CA_BD : 32'h0;

	always_comb begin
		merged = intr_word_q;
		if (audio_from_source_q) begin
			merged[MI_AI] = src_s1[0];
		end
		if (src_s1[1]) merged[MI_SP] = 1'b1;
		if (src_s1[2]) merged[MI_DP] = 1'b1;
	end

	always_comb begin
		status_d    = status_q;
		cause_d     = cause_q;
		epc_d       = epc_q;
		badaddr_d   = badaddr_q;
		context_d   = context_q;
		entryhi_d   = entryhi_q;
		pending_d   = pending_q;
		intr_word_d = intr_word_q;
		intr_mask_d = intr_mask_q;
		npc         = pc_s1;
		ev          = 1'b0;
		tk          = 1'b0;
		case (cmd_s1)
			CMD_CHECK_INTR: begin
				if ((intr_mask_q & merged) != 6'd0) pending_d = pending_q | IP2_LINE;
				else                                pending_d = pending_q & ~IP2_LINE;
				intr_word_d = merged;
				ev = irq_ok && ((status_q[15:8] & pending_d) != 8'd0);
			end
			CMD_ADDR_ERR: begin
				cause_d   = (rd_s1 ? CODE_RADE : CODE_WADE) | bd_bit;
				epc_d     = epc_entry;
				status_d  = status_q | (32'd1 << ST_EXL);
				badaddr_d = fa_s1;
				npc       = VEC_GENERAL;
				tk        = 1'b1;
			end
			CMD_BREAK: begin
				cause_d  = CODE_BRK | bd_bit;
				epc_d    = epc_entry;
				status_d = status_q | (32'd1 << ST_EXL);
				npc      = VEC_GENERAL;
				tk       = 1'b1;
			end
			CMD_COP_UNUSABLE: begin
				cause_d  = CODE_CPU | {2'b00, cop_s1, 28'd0} | bd_bit;
				epc_d    = epc_entry;
				status_d = status_q | (32'd1 << ST_EXL);
				npc      = VEC_GENERAL;
				tk       = 1'b1;
			end
			CMD_INTERRUPT: begin
				if (irq_ok) begin
					cause_d  = CODE_INT | {16'd0, pending_q, 8'd0} | bd_bit;
					epc_d    = epc_entry;
					status_d = status_q | (32'd1 << ST_EXL);
					npc      = VEC_GENERAL;
					tk       = 1'b1;
				end
			end
			CMD_TLB_MISS: begin
				cause_d   = CODE_RMISS;
				badaddr_d = fa_s1;
				context_d = (context_q & CTX_KEEP_MASK) | ((fa_s1 >> 9) & CTX_VPN_MASK);
				entryhi_d = fa_s1 & ENTRYHI_MASK;
				if (!status_q[ST_EXL]) begin
					cause_d  = CODE_RMISS | bd_bit;
					epc_d    = epc_entry;
					status_d = status_q | (32'd1 << ST_EXL);
					npc      = tlbdef_s1 ? VEC_GENERAL : VEC_REFILL;
				end else begin
					npc = VEC_GENERAL;
				end
				tk = 1'b1;
			end
			CMD_SYSCALL: begin
				cause_d  = CODE_SYS | bd_bit;
				epc_d    = epc_entry;
				status_d = status_q | (32'd1 << ST_EXL);
				npc      = VEC_GENERAL;
				tk       = 1'b1;
			end
			CMD_WR_STATUS: status_d    = wv_s1;
			CMD_WR_INTR:   intr_word_d = wv_s1[5:0];
			CMD_WR_MASK:   intr_mask_d = wv_s1[5:0];
			default: begin
			end
		endcase
	end

	// CP0 state: advance with each beat leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= '0;
			cause_q     <= '0;
			epc_q       <= '0;
			badaddr_q   <= '0;
			context_q   <= '0;
			entryhi_q   <= '0;
			pending_q   <= '0;
			intr_word_q <= '0;
			intr_mask_q <= '0;
		end else if (advance) begin
			status_q    <= status_d;
			cause_q     <= cause_d;
			epc_q       <= epc_d;
			badaddr_q   <= badaddr_d;
			context_q   <= context_d;
			entryhi_q   <= entryhi_d;
			pending_q   <= pending_d;
			intr_word_q <= intr_word_d;
			intr_mask_q <= intr_mask_d;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.next_pc    <= npc;
			res_s2.cause      <= cause_d;
			res_s2.epc        <= epc_d;
			res_s2.status     <= status_d;
			res_s2.badaddr    <= badaddr_d;
			res_s2.ctx        <= context_d;
			res_s2.entryhi    <= entryhi_d;
			res_s2.intr_word  <= intr_word_d;
			res_s2.intr_event <= ev;
			res_s2.taken      <= tk;
		end
	end

	assign out_valid     = valid_s2;
	assign next_pc       = res_s2.next_pc;
	assign cause_out     = res_s2.cause;
	assign epc_out       = res_s2.epc;
	assign status_out    = res_s2.status;
	assign badaddr_out   = res_s2.badaddr;
	assign context_out   = res_s2.ctx;
	assign entryhi_out   = res_s2.entryhi;
	assign intr_word_out = res_s2.intr_word;
	assign intr_event    = res_s2.intr_event;
	assign taken         = res_s2.taken;

	a_taken_vector: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && taken |-> (next_pc == VEC_GENERAL || next_pc == VEC_REFILL))
		else $error("taken result without a vector address");

	a_taken_exl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && taken |-> status_out[ST_EXL])
		else $error("exception entered with EXL clear");

	a_event_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(taken && intr_event))
		else $error("interrupt event and exception on one result");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ready |=> valid_s1 && $stable(pc_s1))
		else $error("input stage lost a beat under output stall");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(status_q) && $stable(cause_q) && $stable(epc_q))
		else $error("CP0 state changed without a beat");

endmodule
